@@ rtl/dqidx_pkg.sv @@
// shared types and codes for the indexed double-ended queue
package dqidx_pkg;

   // request operation codes
   localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [2:0] MODE_POP_BACK   = 3'd3;
   localparam logic [2:0] MODE_READ_IDX   = 3'd4;
   localparam logic [2:0] MODE_WRITE_IDX  = 3'd5;

   // response status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam int WORD_W = 32;
   localparam int OCC_W  = 5;

   // per-cycle command broadcast to every cell of the row
   typedef struct packed {
      logic shift_in;   // push front: every word moves one cell toward the back
      logic shift_out;  // pop front: every word moves one cell toward the front
      logic write_at;   // the cell at the target index loads the request word
   } cell_cmd_type;

endpackage

@@ rtl/dqidx_cell.sv @@
// one storage cell of the queue row, holding the word at a fixed index from the front
module dqidx_cell #(
   parameter int INDEX = 0,
   parameter int IDX_W = 4
) (
   input  logic                          clock,
   input  dqidx_pkg::cell_cmd_type       cmd,
   input  logic [IDX_W-1:0]              target,
   input  logic [dqidx_pkg::WORD_W-1:0]  value,
   input  logic [dqidx_pkg::WORD_W-1:0]  left_word,
   input  logic [dqidx_pkg::WORD_W-1:0]  right_word,
   output logic [dqidx_pkg::WORD_W-1:0]  word,
   output logic [dqidx_pkg::WORD_W-1:0]  tap
);
   import dqidx_pkg::*;

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;
   logic              hit;

   assign hit = (target == IDX_W'(INDEX));

   always_comb begin
      word_in = word_ff;
      if (cmd.shift_in) begin
         word_in = left_word;
      end else if (cmd.shift_out) begin
         word_in = right_word;
      end else if (cmd.write_at && hit) begin
         word_in = value;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;
   // only the addressed cell drives its word onto the read collection
   assign tap  = hit ? word_ff : '0;

endmodule

@@ rtl/double_ended_queue_with_index_top.sv @@
// top level of the indexed double-ended queue built as a row of shifting cells
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+--------------------------------------
//   req     | in        | req_valid / req_stall | req_mode, req_value, req_position
//   rsp     | out       | rsp_valid / rsp_stall | rsp_data, rsp_status, rsp_occupancy
//
// one request per cycle unless req_stall is high: the cell row and the count update
// at the accepting edge; the response sits in an output register the following cycle.
// cell i always holds the word at index i from the front, so a push or pop at the
// front shifts the whole row by one cell; indexed access selects one cell by its index.
// reset clears the count and rsp_valid; cells and response payload keep their values.
// a request is stalled only while a response is held and the response side stalls.
module double_ended_queue_with_index_top #(
   parameter int DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_mode,
   input  logic signed [31:0]  req_value,
   input  logic signed [31:0]  req_position,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_data,
   output logic [1:0]          rsp_status,
   output logic [4:0]          rsp_occupancy
);
   import dqidx_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [WORD_W-1:0]  rsp_data_ff;
   logic [WORD_W-1:0]  rsp_data_in;
   logic [1:0]         rsp_status_ff;
   logic [1:0]         rsp_status_in;
   logic [OCC_W-1:0]   rsp_occupancy_ff;

   logic               accept;
   logic               is_empty;
   logic               is_full;
   logic [IDX_W-1:0]   clamped;
   logic [IDX_W-1:0]   last_idx;
   logic [IDX_W-1:0]   target;
   logic [WORD_W-1:0]  collected;
   cell_cmd_type       cmd;

   logic [WORD_W-1:0]  words [DEPTH];
   logic [WORD_W-1:0]  taps  [DEPTH];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign last_idx  = IDX_W'(count_ff - CNT_W'(1));

   // negative positions go to the front, positions at or past the count to the back
   always_comb begin
      if (req_position[31]) begin
         clamped = '0;
      end else if ($unsigned(req_position) >= 32'(count_ff)) begin
         clamped = last_idx;
      end else begin
         clamped = IDX_W'(req_position);
      end
   end

   always_comb begin
      case (req_mode)
         MODE_PUSH_BACK: target = IDX_W'(count_ff);
         MODE_POP_BACK:  target = last_idx;
         default:        target = clamped;
      endcase
   end

   always_comb begin
      cmd           = '0;
      count_in      = count_ff;
      rsp_status_in = STATUS_OK;
      rsp_data_in   = '0;
      case (req_mode)
         MODE_PUSH_FRONT: begin
            if (is_full) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               cmd.shift_in = accept;
               count_in     = count_ff + CNT_W'(1);
            end
         end
         MODE_PUSH_BACK: begin
            if (is_full) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               cmd.write_at = accept;
               count_in     = count_ff + CNT_W'(1);
            end
         end
         MODE_POP_FRONT: begin
            if (is_empty) begin
               rsp_status_in = STATUS_EMPTY;
            end else begin
               cmd.shift_out = accept;
               rsp_data_in   = words[0];
               count_in      = count_ff - CNT_W'(1);
            end
         end
         MODE_POP_BACK: begin
            if (is_empty) begin
               rsp_status_in = STATUS_EMPTY;
            end else begin
               rsp_data_in = collected;
               count_in    = count_ff - CNT_W'(1);
            end
         end
         MODE_READ_IDX: begin
            if (is_empty) begin
               rsp_status_in = STATUS_EMPTY;
            end else begin
               rsp_data_in = collected;
            end
         end
         MODE_WRITE_IDX: begin
            if (is_empty) begin
               rsp_status_in = STATUS_EMPTY;
            end else begin
               cmd.write_at = accept;
            end
         end
         default: begin
            rsp_status_in = STATUS_OK;
         end
      endcase
   end

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         dqidx_cell #(
            .INDEX (gi),
            .IDX_W (IDX_W)
         ) u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .target     (target),
            .value      (req_value),
            .left_word  ((gi == 0) ? WORD_W'(req_value) : words[(gi == 0) ? 0 : gi - 1]),
            .right_word ((gi == DEPTH - 1) ? '0 : words[(gi == DEPTH - 1) ? gi : gi + 1]),
            .word       (words[gi]),
            .tap        (taps[gi])
         );
      end
   endgenerate

   // at most one cell drives a nonzero tap
   always_comb begin
      collected = '0;
      for (int i = 0; i < DEPTH; i++) begin
         collected = collected | taps[i];
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff      <= rsp_data_in;
         rsp_status_ff    <= rsp_status_in;
         rsp_occupancy_ff <= OCC_W'(count_in);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occupancy_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("stored count above depth");

   assert property (@(posedge clock) disable iff (reset)
      accept && (req_mode == MODE_PUSH_FRONT || req_mode == MODE_PUSH_BACK) && is_full
      |=> count_ff == $past(count_ff))
      else $error("dropped push changed the count");

   assert property (@(posedge clock) disable iff (reset)
      accept && (req_mode == MODE_POP_FRONT || req_mode == MODE_POP_BACK) && !is_empty
      |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("pop did not retire one word");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_EMPTY |-> rsp_data_ff == '0)
      else $error("empty response carries data");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !accept ##1 rsp_valid_ff)
      else $error("held response overrun by a new request");

endmodule

@@ tb/tb_double_ended_queue_with_index_top.sv @@
// self-checking testbench for the indexed double-ended queue
`timescale 1ns / 100ps

module tb_double_ended_queue_with_index_top;
   import dqidx_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam int CYCLE_LIMIT = 100000;
   localparam int RANDOM_REQUESTS = 476;
   localparam int CALM_FIRST = 250;
   localparam int CALM_LAST = 370;
   localparam int NUM_VECTORS = 25;

   // mode codes that the block treats as no operation
   localparam logic [2:0] MODE_SPARE_6 = 3'd6;
   localparam logic [2:0] MODE_SPARE_7 = 3'd7;

   typedef struct {
      logic signed [WORD_W-1:0] data;
      logic [1:0]               status;
      logic [OCC_W-1:0]         occupancy;
   } deque_rsp_t;

   typedef struct {
      logic [2:0]          mode;
      logic [WORD_W-1:0]   value;
      logic [WORD_W-1:0]   position;
      int                  reps;
      bit                  typed;
      logic [WORD_W-1:0]   data;
      logic [1:0]          status;
      logic [OCC_W-1:0]    occupancy;
   } deque_vector_t;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [2:0] req_mode;
   logic signed [31:0] req_value;
   logic signed [31:0] req_position;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [31:0] rsp_data;
   logic [1:0] rsp_status;
   logic [4:0] rsp_occupancy;

   // shadow copy of the queue contents
   logic [WORD_W-1:0] shadow_words [QUEUE_DEPTH];
   int shadow_front;
   int shadow_count;

   deque_rsp_t pending_rsps [$];
   deque_rsp_t oldest_rsp;
   deque_vector_t directed_vectors [NUM_VECTORS];
   int error_count;
   int cycle_count;
   bit calm;
   bit filling;

   double_ended_queue_with_index_top #(.DEPTH(QUEUE_DEPTH)) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_value(req_value),
      .req_position(req_position),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .rsp_status(rsp_status),
      .rsp_occupancy(rsp_occupancy)
   );

   always #1 clock = ~clock;

   // applies one request to the shadow queue and returns the response it yields
   function automatic deque_rsp_t apply_deque_op(input logic [2:0] mode,
                                                 input logic [WORD_W-1:0] value,
                                                 input logic signed [WORD_W-1:0] position);
      deque_rsp_t rsp;
      int idx;
      rsp.data = '0;
      rsp.status = STATUS_OK;
      case (mode)
         MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
            if (shadow_count >= QUEUE_DEPTH) begin
               rsp.status = STATUS_FULL;
            end else if (mode == MODE_PUSH_FRONT) begin
               shadow_front = (shadow_front + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
               shadow_words[shadow_front] = value;
               shadow_count++;
            end else begin
               shadow_words[(shadow_front + shadow_count) % QUEUE_DEPTH] = value;
               shadow_count++;
            end
         end
         MODE_POP_FRONT: begin
            if (shadow_count == 0) begin
               rsp.status = STATUS_EMPTY;
            end else begin
               rsp.data = shadow_words[shadow_front];
               shadow_front = (shadow_front + 1) % QUEUE_DEPTH;
               shadow_count--;
            end
         end
         MODE_POP_BACK: begin
            if (shadow_count == 0) begin
               rsp.status = STATUS_EMPTY;
            end else begin
               rsp.data = shadow_words[(shadow_front + shadow_count - 1) % QUEUE_DEPTH];
               shadow_count--;
            end
         end
         MODE_READ_IDX, MODE_WRITE_IDX: begin
            if (shadow_count == 0) begin
               rsp.status = STATUS_EMPTY;
            end else begin
               if (position < 0)
                  idx = 0;
               else if (position >= shadow_count)
                  idx = shadow_count - 1;
               else
                  idx = position;
               idx = (shadow_front + idx) % QUEUE_DEPTH;
               if (mode == MODE_READ_IDX)
                  rsp.data = shadow_words[idx];
               else
                  shadow_words[idx] = value;
            end
         end
         default: ;
      endcase
      rsp.occupancy = shadow_count[OCC_W-1:0];
      return rsp;
   endfunction

   // offers one request, waits for it to be taken, then records its response
   task automatic send_request(input logic [2:0] mode, input logic [WORD_W-1:0] value,
                               input logic [WORD_W-1:0] position, input bit typed,
                               input deque_rsp_t typed_rsp);
      deque_rsp_t predicted;
      while (!calm && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_value <= value;
      req_position <= position;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predicted = apply_deque_op(mode, value, position);
      pending_rsps.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [WORD_W-1:0] pick_value();
      case ($urandom_range(7))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] pick_position();
      case ($urandom_range(9))
         0: return $urandom;
         1: return -$urandom_range(1, 100);
         2: return 32'h7fff_ffff;
         3: return 32'h8000_0000;
         default: return $urandom_range(0, shadow_count + 1);
      endcase
   endfunction

   function automatic logic [2:0] pick_mode();
      int roll;
      if (shadow_count == QUEUE_DEPTH)
         filling = 1'b0;
      else if (shadow_count == 0)
         filling = 1'b1;
      else if ($urandom_range(99) < 3)
         filling = !filling;
      roll = $urandom_range(99);
      if (roll < (filling ? 60 : 15))
         return $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
      else if (roll < (filling ? 75 : 60))
         return $urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT;
      else if (roll < 97)
         return $urandom_range(1) ? MODE_WRITE_IDX : MODE_READ_IDX;
      else
         return $urandom_range(1) ? MODE_SPARE_7 : MODE_SPARE_6;
   endfunction

   // response checker and response-side stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsps.size() == 0) begin
               $error("response with no request outstanding: data %h status %0d",
                      rsp_data, rsp_status);
               error_count++;
            end else begin
               oldest_rsp = pending_rsps.pop_front();
               if (rsp_data !== oldest_rsp.data) begin
                  $error("data: expected %h, actual %h", oldest_rsp.data, rsp_data);
                  error_count++;
               end
               if (rsp_status !== oldest_rsp.status) begin
                  $error("status: expected %0d, actual %0d", oldest_rsp.status, rsp_status);
                  error_count++;
               end
               if (rsp_occupancy !== oldest_rsp.occupancy) begin
                  $error("occupancy: expected %0d, actual %0d", oldest_rsp.occupancy,
                         rsp_occupancy);
                  error_count++;
               end
            end
         end
         rsp_stall <= !calm && ($urandom_range(99) < 10);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      deque_rsp_t typed_rsp;
      deque_vector_t vec;
      clock = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_mode <= MODE_PUSH_FRONT;
      req_value <= '0;
      req_position <= '0;
      error_count = 0;
      cycle_count = 0;
      calm = 1'b0;
      filling = 1'b1;
      shadow_front = 0;
      shadow_count = 0;
      foreach (shadow_words[i])
         shadow_words[i] = '0;

      // mode, value, position, reps, typed, data, status, occupancy
      directed_vectors = '{
         '{MODE_POP_FRONT,  32'h0,         32'h0,         1, 1'b1, 32'h0, STATUS_EMPTY, 5'd0},
         '{MODE_POP_BACK,   32'h0,         32'h0,         1, 1'b1, 32'h0, STATUS_EMPTY, 5'd0},
         '{MODE_READ_IDX,   32'h0,         32'h0,         1, 1'b1, 32'h0, STATUS_EMPTY, 5'd0},
         '{MODE_WRITE_IDX,  32'h1234_5678, 32'h5,         1, 1'b1, 32'h0, STATUS_EMPTY, 5'd0},
         '{MODE_SPARE_6,    32'hffff_ffff, 32'hffff_ffff, 1, 1'b1, 32'h0, STATUS_OK,    5'd0},
         '{MODE_SPARE_7,    32'hffff_ffff, 32'h0,         1, 1'b1, 32'h0, STATUS_OK,    5'd0},
         '{MODE_PUSH_BACK,  32'h7fff_ffff, 32'h0,         1, 1'b1, 32'h0, STATUS_OK,    5'd1},
         '{MODE_PUSH_FRONT, 32'h8000_0000, 32'h0,         1, 1'b1, 32'h0, STATUS_OK,    5'd2},
         // most negative index clamps to the front
         '{MODE_READ_IDX,   32'h0,         32'h8000_0000, 1, 1'b1, 32'h8000_0000, STATUS_OK,
           5'd2},
         // index far past the count clamps to the back
         '{MODE_READ_IDX,   32'h0,         32'h7fff_ffff, 1, 1'b1, 32'h7fff_ffff, STATUS_OK,
           5'd2},
         '{MODE_WRITE_IDX,  32'hffff_ffff, 32'h2,         1, 1'b1, 32'h0, STATUS_OK,    5'd2},
         '{MODE_READ_IDX,   32'h0,         32'h1,         1, 1'b0, 32'h0, STATUS_OK,    5'd0},
         '{MODE_POP_BACK,   32'h0,         32'h0,         1, 1'b0, 32'h0, STATUS_OK,    5'd0},
         '{MODE_POP_FRONT,  32'h0,         32'h0,         1, 1'b0, 32'h0, STATUS_OK,    5'd0},
         '{MODE_PUSH_FRONT, 32'h0000_1000, 32'h0,        16, 1'b0, 32'h0, STATUS_OK,    5'd0},
         '{MODE_PUSH_BACK,  32'h5555_aaaa, 32'h0,         1, 1'b1, 32'h0, STATUS_FULL,  5'd16},
         '{MODE_PUSH_FRONT, 32'haaaa_5555, 32'h0,         1, 1'b1, 32'h0, STATUS_FULL,  5'd16},
         '{MODE_WRITE_IDX,  32'hdead_beef, 32'hf,         1, 1'b0, 32'h0, STATUS_OK,    5'd0},
         '{MODE_READ_IDX,   32'h0,         32'h0,        16, 1'b0, 32'h0, STATUS_OK,    5'd0},
         '{MODE_POP_FRONT,  32'h0,         32'h0,         3, 1'b0, 32'h0, STATUS_OK,    5'd0},
         // pushes at the back now wrap around the ring
         '{MODE_PUSH_BACK,  32'h0000_2000, 32'h0,         3, 1'b0, 32'h0, STATUS_OK,    5'd0},
         '{MODE_POP_BACK,   32'h0,         32'h0,        16, 1'b0, 32'h0, STATUS_OK,    5'd0},
         '{MODE_POP_FRONT,  32'h0,         32'h0,         1, 1'b1, 32'h0, STATUS_EMPTY, 5'd0},
         '{MODE_PUSH_BACK,  32'h0,         32'h0,         1, 1'b1, 32'h0, STATUS_OK,    5'd1},
         '{MODE_SPARE_6,    32'h0,         32'h0,         1, 1'b1, 32'h0, STATUS_OK,    5'd1}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_vectors[v]) begin
         vec = directed_vectors[v];
         typed_rsp.data = vec.data;
         typed_rsp.status = vec.status;
         typed_rsp.occupancy = vec.occupancy;
         for (int r = 0; r < vec.reps; r++)
            send_request(vec.mode, vec.value + r, vec.position + r, vec.typed, typed_rsp);
      end
      wait_for_drain();

      typed_rsp = '{default: '0};
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         calm = (n >= CALM_FIRST) && (n < CALM_LAST);
         if (n % 100 == 99)
            wait_for_drain();
         send_request(pick_mode(), pick_value(), pick_position(), 1'b0, typed_rsp);
      end
      calm = 1'b0;
      wait_for_drain();
      repeat (4) @(posedge clock);

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
